// File: rtl/kwt_pkg.sv
package kwt_pkg;

  typedef enum logic [4:0] {
    KIND_NONE   = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_NAME   = 5'd2,
    KIND_PLUS   = 5'd3,
    KIND_MINUS  = 5'd4,
    KIND_STAR   = 5'd5,
    KIND_SLASH  = 5'd6,
    KIND_LPAREN = 5'd7,
    KIND_RPAREN = 5'd8,
    KIND_SEMI   = 5'd9,
    KIND_COMMA  = 5'd10,
    KIND_IF     = 5'd11,
    KIND_DUMP   = 5'd12,
    KIND_DEL    = 5'd13,
    KIND_ELSE   = 5'd14,
    KIND_SET    = 5'd15,
    KIND_END    = 5'd16,
    KIND_FUNC   = 5'd17,
    KIND_RETURN = 5'd18
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [19:0] start_offset;
    logic [6:0]  token_length;
    logic        too_long;
    logic [47:0] mantissa;
    logic [6:0]  frac_digits;
    logic        final_token;
  } token_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Token text holds the first PREFIX_BYTES bytes, first byte highest.
  localparam int unsigned PREFIX_BYTES = 6;
  localparam int unsigned PREFIX_W     = 8 * PREFIX_BYTES;

  localparam int unsigned NUM_KEYWORDS = 8;
  localparam logic [PREFIX_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    48'h0000_0000_6966, 48'h0000_6475_6D70, 48'h0000_0064_656C, 48'h0000_656C_7365,
    48'h0000_0073_6574, 48'h0000_0065_6E64, 48'h0000_6675_6E63, 48'h7265_7475_726E
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
    3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd6
  };
  localparam kind_e KW_KIND [NUM_KEYWORDS] = '{
    KIND_IF, KIND_DUMP, KIND_DEL, KIND_ELSE, KIND_SET, KIND_END, KIND_FUNC, KIND_RETURN
  };

  // Result queue: two slots must be free before a request is taken.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  function automatic kind_e delim_kind(input logic [7:0] c);
    kind_e k;
    k = KIND_NONE;
    case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3B:   k = KIND_SEMI;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/kwt_classify.sv
module kwt_classify #(
  parameter int unsigned LEN_W = 7
) (
  input  logic [LEN_W-1:0]             tok_len_i,
  input  logic [kwt_pkg::PREFIX_W-1:0] tok_prefix_i,
  input  logic                         numeric_i,
  output kwt_pkg::kind_e               kind_o,
  output logic                         is_num_o
);
  import kwt_pkg::*;

  kind_e kw_kind;
  logic  kw_hit;
  kind_e dk;

  always_comb begin
    kw_kind = KIND_NAME;
    kw_hit  = 1'b0;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (tok_len_i == LEN_W'(KW_LEN[i]) && tok_prefix_i == KW_TEXT[i]) begin
        kw_kind = KW_KIND[i];
        kw_hit  = 1'b1;
      end
    end
  end

  assign dk = delim_kind(tok_prefix_i[7:0]);

  always_comb begin
    kind_o   = KIND_NAME;
    is_num_o = 1'b0;
    if (tok_len_i == LEN_W'(1) && dk != KIND_NONE) begin
      kind_o = dk;
    end else if (kw_hit) begin
      kind_o = kw_kind;
    end else if (numeric_i && tok_len_i != '0) begin
      kind_o   = KIND_NUMBER;
      is_num_o = 1'b1;
    end
  end

endmodule

// File: rtl/kwt_queue.sv
module kwt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  kwt_pkg::token_t push0_i,
  input  kwt_pkg::token_t push1_i,
  output logic            room2_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kwt_pkg::token_t out_data_o
);
  import kwt_pkg::*;

  token_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]   cnt_q, cnt_d;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room2_o     = (cnt_q <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + QUEUE_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + QUEUE_PTR_W'(pop);
  assign cnt_d    = cnt_q + (QUEUE_PTR_W+1)'(push_cnt_i) - (QUEUE_PTR_W+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + QUEUE_PTR_W'(1)] <= push1_i;
    end
  end

endmodule

// File: rtl/keyword_tokenizer.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o   | in_data_i  (kwt_pkg::in_item_t: ch, last_char)
// out      | out_valid_o / out_ready_i | out_data_o (kwt_pkg::token_t, one token each)
//
// One request per cycle while in_ready_o is high: the token state is updated in the
// cycle a byte is taken and its zero, one or two tokens are written into a four-entry
// result queue. in_ready_o is high while the queue has two free slots, so a stalled
// output stops input only once three or more tokens are waiting; tokens leave one per
// cycle while out_ready_i is high. Reset clears the position counters, token state and
// queue; the byte marked last_char returns the token state to its reset values.
module keyword_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = 119,
  parameter int unsigned OFFSET_BITS   = 20,
  parameter int unsigned MANTISSA_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kwt_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kwt_pkg::token_t   out_data_o
);
  import kwt_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned OFF_W  = OFFSET_BITS;
  localparam int unsigned MANT_W = MANTISSA_BITS;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  // Token and position state
  logic                in_token_q;
  logic [15:0]         cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [OFF_W-1:0]    cur_off_q, cur_off_d;
  logic [15:0]         tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [OFF_W-1:0]    tok_off_q, tok_off_d;
  logic [LEN_W-1:0]    tok_len_q, tok_len_d;
  logic [PREFIX_W-1:0] tok_prefix_q, tok_prefix_d;
  logic                numeric_q, numeric_d, dot_q, dot_d, ovf_q, ovf_d;
  logic [MANT_W-1:0]   digit_val_q, digit_val_d;
  logic [LEN_W-1:0]    frac_q, frac_d;

  logic       accept, last, is_ws, is_delim, is_digit, is_dot, start, sel_new;
  logic [7:0] ch;
  kind_e      ch_kind;

  logic [MANT_W+3:0] mul10;
  logic [LEN_W-1:0]  base_len, base_frac;
  logic [MANT_W-1:0] base_val;

  logic [LEN_W-1:0]    cls_len, cls_frac;
  logic [PREFIX_W-1:0] cls_prefix;
  logic                cls_numeric, cls_ovf, cls_is_num;
  logic [MANT_W-1:0]   cls_val;
  logic [15:0]         cls_line, cls_col;
  logic [OFF_W-1:0]    cls_off;
  kind_e               cls_kind;

  logic [63:0] len_ext, frac_ext, mant_ext, off_ext, cur_off_ext, nxt_off_ext;
  token_t      tok_res, none_res, delim_res, push0, push1;
  logic [1:0]  push_n, push_cnt;
  logic        room2;

  assign ch       = in_data_i.ch;
  assign last     = in_data_i.last_char;
  assign accept   = in_valid_i && in_ready_o;
  assign ch_kind  = delim_kind(ch);
  assign is_ws    = (ch == CH_SPACE) || (ch == CH_NEWLINE);
  assign is_delim = (ch_kind != KIND_NONE);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_dot   = (ch == CH_DOT);
  assign start    = !in_token_q;
  // The byte joins a token (new or open) unless it is whitespace or ends an open token.
  assign sel_new  = !is_ws && !(in_token_q && is_delim);

  // Token state after this byte is added
  always_comb begin
    base_len     = start ? '0 : tok_len_q;
    base_frac    = start ? '0 : frac_q;
    base_val     = start ? '0 : digit_val_q;
    tok_line_d   = start ? cur_line_q : tok_line_q;
    tok_col_d    = start ? cur_col_q : tok_col_q;
    tok_off_d    = start ? cur_off_q : tok_off_q;
    tok_prefix_d = start ? '0 : tok_prefix_q;
    numeric_d    = start ? 1'b1 : numeric_q;
    dot_d        = start ? 1'b0 : dot_q;
    ovf_d        = start ? 1'b0 : ovf_q;

    if (base_len < LEN_W'(PREFIX_BYTES)) begin
      tok_prefix_d = {tok_prefix_d[PREFIX_W-9:0], ch};
    end
    if (base_len < LEN_MAX) begin
      tok_len_d = base_len + LEN_W'(1);
    end else begin
      tok_len_d = base_len;
      ovf_d     = 1'b1;
    end

    mul10 = ({4'b0, base_val} << 3) + ({4'b0, base_val} << 1)
          + (MANT_W+4)'(ch[3:0]);
    digit_val_d = base_val;
    frac_d      = base_frac;
    if (is_digit) begin
      // Saturate once the scaled value no longer fits
      digit_val_d = (mul10[MANT_W+3:MANT_W] != 4'd0) ? '1 : mul10[MANT_W-1:0];
      if (dot_d && base_frac < LEN_MAX) begin
        frac_d = base_frac + LEN_W'(1);
      end
    end else if (is_dot) begin
      if (dot_d) begin
        numeric_d = 1'b0;
      end
      dot_d = 1'b1;
    end else begin
      numeric_d = 1'b0;
    end
  end

  // Position after this byte
  always_comb begin
    cur_off_d = cur_off_q + OFF_W'(1);
    if (ch == CH_NEWLINE) begin
      cur_line_d = sat_inc16(cur_line_q);
      cur_col_d  = 16'd1;
    end else begin
      cur_line_d = cur_line_q;
      cur_col_d  = sat_inc16(cur_col_q);
    end
  end

  // Token to report: the open one, or the one just extended by this byte
  always_comb begin
    cls_len     = sel_new ? tok_len_d : tok_len_q;
    cls_prefix  = sel_new ? tok_prefix_d : tok_prefix_q;
    cls_numeric = sel_new ? numeric_d : numeric_q;
    cls_ovf     = sel_new ? ovf_d : ovf_q;
    cls_val     = sel_new ? digit_val_d : digit_val_q;
    cls_frac    = sel_new ? frac_d : frac_q;
    cls_line    = sel_new ? tok_line_d : tok_line_q;
    cls_col     = sel_new ? tok_col_d : tok_col_q;
    cls_off     = sel_new ? tok_off_d : tok_off_q;
  end

  kwt_classify #(
    .LEN_W(LEN_W)
  ) u_classify (
    .tok_len_i   (cls_len),
    .tok_prefix_i(cls_prefix),
    .numeric_i   (cls_numeric),
    .kind_o      (cls_kind),
    .is_num_o    (cls_is_num)
  );

  assign len_ext     = 64'(cls_len);
  assign frac_ext    = 64'(cls_frac);
  assign mant_ext    = 64'(cls_val);
  assign off_ext     = 64'(cls_off);
  assign cur_off_ext = 64'(cur_off_q);
  assign nxt_off_ext = 64'(cur_off_d);

  always_comb begin
    tok_res.token_kind   = cls_kind;
    tok_res.start_line   = cls_line;
    tok_res.start_col    = cls_col;
    tok_res.start_offset = off_ext[19:0];
    tok_res.token_length = len_ext[6:0];
    tok_res.too_long     = cls_ovf;
    tok_res.mantissa     = cls_is_num ? mant_ext[47:0] : 48'd0;
    tok_res.frac_digits  = cls_is_num ? frac_ext[6:0] : 7'd0;
    tok_res.final_token  = sel_new;

    none_res.token_kind   = KIND_NONE;
    none_res.start_line   = cur_line_d;
    none_res.start_col    = cur_col_d;
    none_res.start_offset = nxt_off_ext[19:0];
    none_res.token_length = 7'd0;
    none_res.too_long     = 1'b0;
    none_res.mantissa     = 48'd0;
    none_res.frac_digits  = 7'd0;
    none_res.final_token  = 1'b1;

    delim_res.token_kind   = ch_kind;
    delim_res.start_line   = cur_line_q;
    delim_res.start_col    = cur_col_q;
    delim_res.start_offset = cur_off_ext[19:0];
    delim_res.token_length = 7'd1;
    delim_res.too_long     = 1'b0;
    delim_res.mantissa     = 48'd0;
    delim_res.frac_digits  = 7'd0;
    delim_res.final_token  = last;
  end

  // Pack results into queue slots in order
  always_comb begin
    push0  = tok_res;
    push1  = none_res;
    push_n = 2'd0;
    if (is_ws) begin
      if (in_token_q) begin
        push_n = last ? 2'd2 : 2'd1;
      end else begin
        push0  = none_res;
        push_n = last ? 2'd1 : 2'd0;
      end
    end else if (in_token_q && is_delim) begin
      push1  = delim_res;
      push_n = 2'd2;
    end else begin
      push_n = last ? 2'd1 : 2'd0;
    end
  end

  assign push_cnt   = accept ? push_n : 2'd0;
  assign in_ready_o = room2;

  kwt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .room2_o    (room2),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q   <= 1'b0;
      cur_line_q   <= 16'd1;
      cur_col_q    <= 16'd1;
      cur_off_q    <= '0;
      tok_line_q   <= 16'd1;
      tok_col_q    <= 16'd1;
      tok_off_q    <= '0;
      tok_len_q    <= '0;
      tok_prefix_q <= '0;
      numeric_q    <= 1'b1;
      dot_q        <= 1'b0;
      ovf_q        <= 1'b0;
      digit_val_q  <= '0;
      frac_q       <= '0;
    end else if (accept) begin
      if (last) begin
        // End of text: start over
        in_token_q   <= 1'b0;
        cur_line_q   <= 16'd1;
        cur_col_q    <= 16'd1;
        cur_off_q    <= '0;
        tok_line_q   <= 16'd1;
        tok_col_q    <= 16'd1;
        tok_off_q    <= '0;
        tok_len_q    <= '0;
        tok_prefix_q <= '0;
        numeric_q    <= 1'b1;
        dot_q        <= 1'b0;
        ovf_q        <= 1'b0;
        digit_val_q  <= '0;
        frac_q       <= '0;
      end else begin
        cur_line_q <= cur_line_d;
        cur_col_q  <= cur_col_d;
        cur_off_q  <= cur_off_d;
        in_token_q <= sel_new;
        if (sel_new) begin
          tok_line_q   <= tok_line_d;
          tok_col_q    <= tok_col_d;
          tok_off_q    <= tok_off_d;
          tok_len_q    <= tok_len_d;
          tok_prefix_q <= tok_prefix_d;
          numeric_q    <= numeric_d;
          dot_q        <= dot_d;
          ovf_q        <= ovf_d;
          digit_val_q  <= digit_val_d;
          frac_q       <= frac_d;
        end
      end
    end
  end

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kwt_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_ITEMS   = 440;
  localparam int PHASE_ITEMS    = 110;
  localparam int MAX_REPORTS    = 40;
  localparam logic [6:0]  LEN_LIMIT = 7'd119;
  localparam logic [63:0] MANT_MAX  = 64'hFFFF_FFFF_FFFF;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  token_t    out_data;

  keyword_tokenizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lexer state mirrored from the block
  logic        open_tok;
  logic [15:0] line_q, col_q, tline, tcol;
  logic [19:0] off_q, toff;
  logic [6:0]  tlen, frac_cnt;
  logic [47:0] tpref, mant_acc;
  logic        all_digits, has_dot, overlong;

  token_t      tokens_due[$];
  logic [7:0]  text_buf[$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_request = 1'b0;
  int          quiet_cycles = 0;

  string field_names [9] = '{"token_kind", "start_line", "start_col", "start_offset",
                             "token_length", "too_long", "mantissa", "frac_digits",
                             "final_token"};
  string kw_words [8] = '{"if", "dump", "del", "else", "set", "end", "func", "return"};
  string punct_chars = "+-*/();,";

  function automatic kind_e punct_kind(input logic [7:0] c);
    case (c)
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "/":     return KIND_SLASH;
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      ";":     return KIND_SEMI;
      ",":     return KIND_COMMA;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic kind_e keyword_kind(input logic [6:0] len, input logic [47:0] pref);
    if (len == 7'd2 && pref == 48'h6966)         return KIND_IF;
    if (len == 7'd4 && pref == 48'h6475_6D70)    return KIND_DUMP;
    if (len == 7'd3 && pref == 48'h64_656C)      return KIND_DEL;
    if (len == 7'd4 && pref == 48'h656C_7365)    return KIND_ELSE;
    if (len == 7'd3 && pref == 48'h73_6574)      return KIND_SET;
    if (len == 7'd3 && pref == 48'h65_6E64)      return KIND_END;
    if (len == 7'd4 && pref == 48'h6675_6E63)    return KIND_FUNC;
    if (len == 7'd6 && pref == 48'h7265_7475_726E) return KIND_RETURN;
    return KIND_NAME;
  endfunction

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [63:0] field_of(input token_t t, input int idx);
    case (idx)
      0:       return 64'(t.token_kind);
      1:       return 64'(t.start_line);
      2:       return 64'(t.start_col);
      3:       return 64'(t.start_offset);
      4:       return 64'(t.token_length);
      5:       return 64'(t.too_long);
      6:       return 64'(t.mantissa);
      7:       return 64'(t.frac_digits);
      default: return 64'(t.final_token);
    endcase
  endfunction

  task automatic clear_state();
    open_tok   = 1'b0;
    line_q     = 16'd1;
    col_q      = 16'd1;
    off_q      = '0;
    tline      = 16'd1;
    tcol       = 16'd1;
    toff       = '0;
    tlen       = '0;
    tpref      = '0;
    all_digits = 1'b1;
    has_dot    = 1'b0;
    mant_acc   = '0;
    frac_cnt   = '0;
    overlong   = 1'b0;
  endtask

  task automatic open_new_token();
    open_tok   = 1'b1;
    tline      = line_q;
    tcol       = col_q;
    toff       = off_q;
    tlen       = '0;
    tpref      = '0;
    all_digits = 1'b1;
    has_dot    = 1'b0;
    mant_acc   = '0;
    frac_cnt   = '0;
    overlong   = 1'b0;
  endtask

  task automatic absorb(input logic [7:0] c);
    logic [63:0] d;
    if (tlen < 7'd6) tpref = {tpref[39:0], c};
    if (tlen < LEN_LIMIT) tlen = tlen + 7'd1;
    else overlong = 1'b1;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 64'(c - CH_ZERO);
      if (64'(mant_acc) > (MANT_MAX - d) / 64'd10) mant_acc = MANT_MAX[47:0];
      else mant_acc = 48'(64'(mant_acc) * 64'd10 + d);
      if (has_dot && frac_cnt < LEN_LIMIT) frac_cnt = frac_cnt + 7'd1;
    end else if (c == CH_DOT) begin
      if (has_dot) all_digits = 1'b0;
      has_dot = 1'b1;
    end else begin
      all_digits = 1'b0;
    end
  endtask

  task automatic step_position(input logic [7:0] c);
    off_q = off_q + 20'd1;
    if (c == CH_NEWLINE) begin
      line_q = bump16(line_q);
      col_q  = 16'd1;
    end else begin
      col_q = bump16(col_q);
    end
  endtask

  task automatic close_token(input logic fin);
    token_t t;
    kind_e  k;
    if (tlen == 7'd1 && punct_kind(tpref[7:0]) != KIND_NONE) begin
      k = punct_kind(tpref[7:0]);
    end else begin
      k = keyword_kind(tlen, tpref);
      if (k == KIND_NAME && all_digits) k = KIND_NUMBER;
    end
    t.token_kind   = k;
    t.start_line   = tline;
    t.start_col    = tcol;
    t.start_offset = toff;
    t.token_length = tlen;
    t.too_long     = overlong;
    t.mantissa     = (k == KIND_NUMBER) ? mant_acc : '0;
    t.frac_digits  = (k == KIND_NUMBER) ? frac_cnt : '0;
    t.final_token  = fin;
    tokens_due.push_back(t);
    open_tok = 1'b0;
  endtask

  // Work out the tokens that one byte releases
  task automatic lex_char(input logic [7:0] c, input logic lst);
    token_t t;
    if (c == CH_SPACE || c == CH_NEWLINE) begin
      if (open_tok) close_token(1'b0);
      step_position(c);
      if (lst) begin
        t = '0;
        t.token_kind   = KIND_NONE;
        t.start_line   = line_q;
        t.start_col    = col_q;
        t.start_offset = off_q;
        t.final_token  = 1'b1;
        tokens_due.push_back(t);
      end
    end else if (open_tok && punct_kind(c) != KIND_NONE) begin
      close_token(1'b0);
      open_new_token();
      absorb(c);
      step_position(c);
      close_token(lst);
    end else begin
      if (!open_tok) open_new_token();
      absorb(c);
      step_position(c);
      if (lst) close_token(1'b1);
    end
    if (lst) clear_state();
  endtask

  // Offer one request; returns right after the edge that accepts it
  task automatic send_char(input logic [7:0] c, input logic lst);
    in_item_t item;
    item.ch        = c;
    item.last_char = lst;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    lex_char(c, lst);
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_str(input string s, input logic mark_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], mark_last && (i == s.len() - 1));
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic add_number();
    int ndig, dot_at;
    ndig   = $urandom_range(1, 18);
    dot_at = ($urandom_range(1) == 1) ? int'($urandom_range(0, ndig)) : -1;
    for (int i = 0; i < ndig; i++) begin
      if (i == dot_at) text_buf.push_back(CH_DOT);
      text_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
    if (dot_at == ndig) text_buf.push_back(CH_DOT);
    // an extra dot turns it into a name if it already holds one
    if ($urandom_range(9) == 0) text_buf.push_back(CH_DOT);
  endtask

  task automatic add_name();
    int n;
    if ($urandom_range(3) == 0) add_str(kw_words[$urandom_range(7)]);
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0:       text_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
        1:       text_buf.push_back("_");
        default: text_buf.push_back(8'("a" + $urandom_range(25)));
      endcase
    end
  endtask

  task automatic add_long_token();
    int n;
    logic digits_only;
    n = $urandom_range(100, 130);
    digits_only = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      if (digits_only && i == 3) text_buf.push_back(CH_DOT);
      else if (digits_only) text_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      else text_buf.push_back(8'("a" + $urandom_range(25)));
    end
  endtask

  task automatic add_piece();
    int r;
    r = $urandom_range(99);
    if (r < 20) add_str(kw_words[$urandom_range(7)]);
    else if (r < 40) add_number();
    else if (r < 58) add_name();
    else if (r < 80) text_buf.push_back(punct_chars[$urandom_range(7)]);
    else if (r < 98) text_buf.push_back(8'($urandom_range(255)));
    else add_long_token();
    r = $urandom_range(99);
    if (r < 35) begin
      // glue the next piece on directly
    end else if (r < 70) begin
      text_buf.push_back(CH_SPACE);
    end else if (r < 85) begin
      text_buf.push_back(CH_NEWLINE);
    end else begin
      repeat ($urandom_range(2, 3))
        text_buf.push_back($urandom_range(1) ? CH_SPACE : CH_NEWLINE);
    end
  endtask

  task automatic test_keywords();
    send_str("if dump del else set end func return iff ret", 1'b1);
  endtask

  task automatic test_operators();
    send_str("a+b-c*d/e(f)g;h,i +x ,", 1'b1);
    send_str("x(+y", 1'b1);
  endtask

  task automatic test_numbers();
    send_str("0 9 12.5 .5 5. . 1.2.3 007 281474976710655 281474976710656", 1'b0);
    send_str(" 99999999999999999999 -7 3x", 1'b1);
    send_str(" \n", 1'b1);
  endtask

  task automatic test_odd_bytes();
    send_char(8'h00, 1'b0);
    send_char(8'h09, 1'b0);
    send_char(8'h0D, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_SPACE, 1'b1);
    send_char("x", 1'b1);
    send_char(CH_SPACE, 1'b1);
    send_char(CH_NEWLINE, 1'b1);
    send_char(";", 1'b1);
  endtask

  task automatic test_long_tokens();
    repeat (125) text_buf.push_back("q");
    text_buf.push_back(CH_SPACE);
    add_str("1.");
    repeat (125) text_buf.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
    text_buf.push_back(CH_NEWLINE);
    send_text();
  endtask

  // Stall the output long enough that the result queue fills and input stops
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (30) add_str("a;");
    send_text();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ((sent / PHASE_ITEMS) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 20)) text_buf.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 12)) add_piece();
        if ($urandom_range(99) < 30) text_buf.push_back(CH_SPACE);
      end
      sent += text_buf.size();
      send_text();
    end
  endtask

  task automatic check_token(input token_t got);
    token_t want;
    if (tokens_due.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: unexpected token, expected none, actual %h", $time, got);
    end else begin
      want = tokens_due.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (field_of(got, i) !== field_of(want, i)) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: %s expected %0h actual %0h", $time, field_names[i],
                     field_of(want, i), field_of(got, i));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) check_token(out_data);
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_keywords();
    test_operators();
    test_numbers();
    test_odd_bytes();
    test_long_tokens();
    test_backpressure();
    test_random();
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (tokens_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kwt_pkg.sv
rtl/kwt_classify.sv
rtl/kwt_queue.sv
rtl/keyword_tokenizer.sv
bench/tb_top.sv
